>>> rtl/edge_vertex_transform_2d_core_macros.svh
// Assertion macros for the edge vertex transform core.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef EDGE_VERTEX_TRANSFORM_2D_CORE_MACROS_SVH
`define EDGE_VERTEX_TRANSFORM_2D_CORE_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define EVT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("evt implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define EVT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("evt next-cycle check failed");
`endif

>>> rtl/evt_pkg.sv
// Shared types, constants and helper functions for the edge vertex transform.
// No dependencies.
package evt_pkg;

	localparam int unsigned MaxPoints = 256;
	localparam int unsigned SlotW = $clog2(MaxPoints);
	localparam int unsigned ScreenWidth = 800;
	localparam int unsigned ScreenHeight = 600;

	// Configuration register indexes.
	localparam logic [2:0] REG_ANGLE = 3'd0;
	localparam logic [2:0] REG_SCALE_X = 3'd1;
	localparam logic [2:0] REG_SCALE_Y = 3'd2;
	localparam logic [2:0] REG_OFFSET_X = 3'd3;
	localparam logic [2:0] REG_OFFSET_Y = 3'd4;

	// Request codes.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EDGE = 1'b1;

	localparam int unsigned ProdW = 62;

	typedef struct packed {
		logic req_type;
		logic [7:0] point_slot;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic [7:0] first_vertex;
		logic [7:0] second_vertex;
		logic last_edge;
	} in_item_t;

	typedef struct packed {
		logic signed [11:0] screen_x1;
		logic signed [11:0] screen_y1;
		logic signed [11:0] screen_x2;
		logic signed [11:0] screen_y2;
		logic frame_end;
	} out_item_t;

	// Stage enables of the endpoint pipeline.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	// Rotation coefficients in Q1.14 plus the unit's busy flag.
	typedef struct packed {
		logic signed [15:0] cos_v;
		logic signed [15:0] sin_v;
		logic busy;
	} trig_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_RUN,
		CS_DONE
	} cordic_state_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [29:0] arc_step(input logic [3:0] i);
		logic [29:0] r;
		case (i)
			4'd0: r = 30'd536870912;
			4'd1: r = 30'd316933406;
			4'd2: r = 30'd167458907;
			4'd3: r = 30'd85004756;
			4'd4: r = 30'd42667331;
			4'd5: r = 30'd21354465;
			4'd6: r = 30'd10679838;
			4'd7: r = 30'd5340245;
			4'd8: r = 30'd2670163;
			4'd9: r = 30'd1335087;
			4'd10: r = 30'd667544;
			4'd11: r = 30'd333772;
			4'd12: r = 30'd166886;
			4'd13: r = 30'd83443;
			4'd14: r = 30'd41722;
			default: r = 30'd20861;
		endcase
		return r;
	endfunction

	// Divide by 2^35 truncating toward zero, then saturate to 12-bit signed.
	function automatic logic signed [11:0] scale_sat(input logic signed [ProdW-1:0] p);
		logic signed [ProdW-1:0] b;
		logic signed [ProdW-1:0] q;
		logic signed [11:0] r;
		b = p[ProdW-1] ? p + ProdW'(64'h7_FFFF_FFFF) : p;
		q = b >>> 35;
		if (q > ProdW'(2047))
			r = 12'sd2047;
		else if (q < -ProdW'(2048))
			r = -12'sd2048;
		else
			r = q[11:0];
		return r;
	endfunction

endpackage

>>> rtl/evt_cordic.sv
// Iterative CORDIC that turns the rotation angle into cosine and sine (Q1.14).
// Depends on evt_pkg.
module evt_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] angle,
	output evt_pkg::trig_t trig
);
	import evt_pkg::*;

	localparam logic signed [33:0] XInit = 34'sd652032874;

	cordic_state_t state_q, state_next;
	logic signed [33:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [3:0] step_q;
	logic [1:0] quad_q;
	logic signed [15:0] cos_q, sin_q;
	logic signed [33:0] dx, dy, arc;
	logic signed [15:0] c_fin, s_fin;
	logic resid_zero;

	// Round half up from Q2.30 to Q1.14 and clamp to plus or minus one.
	function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
		logic signed [34:0] t;
		logic signed [34:0] r;
		logic signed [15:0] o;
		t = 35'(v) + 35'sd32768;
		r = t >>> 16;
		if (r > 35'sd16384)
			o = 16'sd16384;
		else if (r < -35'sd16384)
			o = -16'sd16384;
		else
			o = r[15:0];
		return o;
	endfunction

	assign resid_zero = (angle[13:0] == 14'd0);
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign arc = 34'(arc_step(step_q));
	assign c_fin = to_q14(x_q);
	assign s_fin = to_q14(y_q);

	// Next state.
	always_comb begin
		state_next = state_q;
		if (start) begin
			state_next = resid_zero ? CS_IDLE : CS_RUN;
		end else begin
			case (state_q)
				CS_IDLE: state_next = CS_IDLE;
				CS_RUN: state_next = (step_q == 4'd15) ? CS_DONE : CS_RUN;
				CS_DONE: state_next = CS_IDLE;
				default: state_next = CS_IDLE;
			endcase
		end
	end

	// Outputs.
	always_comb begin
		trig.cos_v = cos_q;
		trig.sin_v = sin_q;
		trig.busy = (state_q != CS_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Iteration registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= angle[15:14];
			x_q <= XInit;
			y_q <= '0;
			z_q <= signed'({2'b00, angle[13:0], 16'd0});
			step_q <= '0;
		end else if (state_q == CS_RUN) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - arc[31:0];
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + arc[31:0];
			end
			step_q <= step_q + 4'd1;
		end
	end

	// Coefficient registers with quadrant mapping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= 16'sd16384;
			sin_q <= '0;
		end else if (start && resid_zero) begin
			case (angle[15:14])
				2'd0: begin cos_q <= 16'sd16384; sin_q <= '0; end
				2'd1: begin cos_q <= '0; sin_q <= 16'sd16384; end
				2'd2: begin cos_q <= -16'sd16384; sin_q <= '0; end
				default: begin cos_q <= '0; sin_q <= -16'sd16384; end
			endcase
		end else if (!start && state_q == CS_DONE) begin
			case (quad_q)
				2'd0: begin cos_q <= c_fin; sin_q <= s_fin; end
				2'd1: begin cos_q <= -s_fin; sin_q <= c_fin; end
				2'd2: begin cos_q <= -c_fin; sin_q <= -s_fin; end
				default: begin cos_q <= s_fin; sin_q <= -c_fin; end
			endcase
		end
	end

endmodule

>>> rtl/evt_endpoint.sv
// Five-stage datapath that maps one model point to a screen pixel.
// Depends on evt_pkg.
module evt_endpoint (
	input logic clk,
	input evt_pkg::pipe_en_t en,
	input logic signed [15:0] px,
	input logic signed [15:0] py,
	input evt_pkg::trig_t trig,
	input logic signed [15:0] scale_x,
	input logic signed [15:0] scale_y,
	input logic signed [15:0] offset_x,
	input logic signed [15:0] offset_y,
	output logic signed [11:0] col,
	output logic signed [11:0] row
);
	import evt_pkg::*;

	localparam logic signed [49:0] One34 = 50'sd17179869184;
	localparam logic signed [ProdW-1:0] Wc = ProdW'(ScreenWidth);
	localparam logic signed [ProdW-1:0] Hc = ProdW'(ScreenHeight);

	logic signed [31:0] pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [32:0] rx_s3, ry_s3;
	logic signed [48:0] nx_s4, ny_s4;
	logic signed [ProdW-1:0] cp_s5, rp_s5;
	logic signed [11:0] col_s6, row_s6;

	// Rotation products.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pxc_s2 <= px * trig.cos_v;
			pys_s2 <= py * trig.sin_v;
			pxs_s2 <= px * trig.sin_v;
			pyc_s2 <= py * trig.cos_v;
		end
	end

	// Rotated point in Q.22.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			rx_s3 <= 33'(pxc_s2) - 33'(pys_s2);
			ry_s3 <= 33'(pxs_s2) + 33'(pyc_s2);
		end
	end

	// Scale and translate at Q.34.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			nx_s4 <= 49'(rx_s3) * 49'(scale_x) + (49'(offset_x) <<< 22);
			ny_s4 <= 49'(ry_s3) * 49'(scale_y) + (49'(offset_y) <<< 22);
		end
	end

	// Screen mapping products.
	always_ff @(posedge clk) begin
		if (en.s5) begin
			cp_s5 <= ProdW'(50'(nx_s4) + One34) * Wc;
			rp_s5 <= ProdW'(One34 - 50'(ny_s4)) * Hc;
		end
	end

	// Truncating divide and saturation.
	always_ff @(posedge clk) begin
		if (en.s6) begin
			col_s6 <= scale_sat(cp_s5);
			row_s6 <= scale_sat(rp_s5);
		end
	end

	assign col = col_s6;
	assign row = row_s6;

endmodule

>>> rtl/edge_vertex_transform_2d_core.sv
// Top level of the 2D edge vertex transform: point store, pipeline control, registers.
// Depends on evt_pkg, evt_cordic, evt_endpoint and the assertion macro header.
//
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  in_item (evt_pkg::in_item_t)
// out      out  out_valid/out_stall out_item (evt_pkg::out_item_t)
// cfg      in   cfg_we             cfg_index, cfg_data
//
// One item per cycle while in_stall is low; an edge result passes through the point
// store read and then five endpoint datapath stages. Loads give no result.
// A write to the rotation angle that is not a multiple of a quarter turn runs the
// CORDIC, and in_stall is high while it runs. Each stage advances when it is empty or
// the next one advances, so bubbles are squeezed out under out_stall. Reset clears
// valid bits and configuration registers; the point store is not cleared.
module edge_vertex_transform_2d_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input evt_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output evt_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	import evt_pkg::*;

	`include "edge_vertex_transform_2d_core_macros.svh"

	logic [31:0] store_mem [MaxPoints];
	logic [31:0] p1_s1, p2_s1;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic [5:0] last_q;
	logic en1;
	pipe_en_t en;
	logic in_acc;
	logic signed [15:0] scale_x_q, scale_y_q, offset_x_q, offset_y_q;
	trig_t trig;
	logic angle_wr;

	// Stage enables from the output back.
	assign en.s6 = !v6_s6 || !out_stall;
	assign en.s5 = !v5_s5 || en.s6;
	assign en.s4 = !v4_s4 || en.s5;
	assign en.s3 = !v3_s3 || en.s4;
	assign en.s2 = !v2_s2 || en.s3;
	assign en1 = !v1_s1 || en.s2;

	assign in_stall = trig.busy || !en1;
	assign in_acc = in_valid && !in_stall;

	// Configuration registers.
	assign angle_wr = cfg_we && (cfg_index == REG_ANGLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= 16'sd410;
			scale_y_q <= 16'sd410;
			offset_x_q <= -16'sd3686;
			offset_y_q <= -16'sd1638;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE_X: scale_x_q <= cfg_data;
				REG_SCALE_Y: scale_y_q <= cfg_data;
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	evt_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(angle_wr),
		.angle(cfg_data),
		.trig(trig)
	);

	// Point store: loads write, edges read both endpoints.
	always_ff @(posedge clk) begin
		if (in_acc && in_item.req_type == REQ_LOAD)
			store_mem[in_item.point_slot[SlotW-1:0]] <= {in_item.point_x, in_item.point_y};
		if (en1) begin
			p1_s1 <= store_mem[in_item.first_vertex[SlotW-1:0]];
			p2_s1 <= store_mem[in_item.second_vertex[SlotW-1:0]];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_acc && (in_item.req_type == REQ_EDGE);
			if (en.s2) v2_s2 <= v1_s1;
			if (en.s3) v3_s3 <= v2_s2;
			if (en.s4) v4_s4 <= v3_s3;
			if (en.s5) v5_s5 <= v4_s4;
			if (en.s6) v6_s6 <= v5_s5;
		end
	end

	// Last-edge flag alongside the stages.
	always_ff @(posedge clk) begin
		if (en1) last_q[0] <= in_item.last_edge;
		if (en.s2) last_q[1] <= last_q[0];
		if (en.s3) last_q[2] <= last_q[1];
		if (en.s4) last_q[3] <= last_q[2];
		if (en.s5) last_q[4] <= last_q[3];
		if (en.s6) last_q[5] <= last_q[4];
	end

	evt_endpoint u_ep1 (
		.clk(clk),
		.en(en),
		.px(p1_s1[31:16]),
		.py(p1_s1[15:0]),
		.trig(trig),
		.scale_x(scale_x_q),
		.scale_y(scale_y_q),
		.offset_x(offset_x_q),
		.offset_y(offset_y_q),
		.col(out_item.screen_x1),
		.row(out_item.screen_y1)
	);

	evt_endpoint u_ep2 (
		.clk(clk),
		.en(en),
		.px(p2_s1[31:16]),
		.py(p2_s1[15:0]),
		.trig(trig),
		.scale_x(scale_x_q),
		.scale_y(scale_y_q),
		.offset_x(offset_x_q),
		.offset_y(offset_y_q),
		.col(out_item.screen_x2),
		.row(out_item.screen_y2)
	);

	assign out_item.frame_end = last_q[5];
	assign out_valid = v6_s6;

	// No item enters while the CORDIC runs.
	`EVT_ASSERT_IMP(a_busy_blocks_input, trig.busy, in_stall)
	// An accepted edge occupies the first stage next cycle.
	`EVT_ASSERT_NXT(a_edge_enters, in_acc && in_item.req_type == REQ_EDGE, v1_s1)
	// A load never creates a pipeline entry.
	`EVT_ASSERT_NXT(a_load_no_entry, in_acc && in_item.req_type == REQ_LOAD, !v1_s1)
	// A stalled result keeps the last stage occupied.
	`EVT_ASSERT_NXT(a_hold_last, v6_s6 && out_stall, v6_s6)

endmodule
